// ----- hdl/timestamp_kway_merge_core_macros.svh -----
// Assertion macros shared by the timestamp merge checker.
`ifndef TIMESTAMP_KWAY_MERGE_CORE_MACROS_SVH
`define TIMESTAMP_KWAY_MERGE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TKM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tkm_pkg.sv -----
// Shared widths, op codes and controller/datapath handshake types of the timestamp merge.
package tkm_pkg;

  localparam int OP_W   = 2;
  localparam int SRC_W  = 4;
  localparam int TIME_W = 64;
  localparam int PL_W   = 32;

  localparam int NUM_SOURCES_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STEP   = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic head_wr;   // write a source head and mark it valid
    logic head_rm;   // clear a source's valid mark
    logic scan_clr;  // start a new scan for the oldest head
    logic scan_rd;   // read the next head of the scan
    logic res_zero;  // post an empty result word
    logic res_best;  // post the scan winner and retire it
  } tkm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
    logic rd_last;   // the scan address points at the last source
  } tkm_stat_t;

endpackage

// ----- hdl/tkm_if.sv -----
// Valid/ready channel interfaces for the input and result words of the timestamp merge.
interface tkm_in_if;
  logic                       valid;
  logic                       ready;
  logic [tkm_pkg::OP_W-1:0]   op;
  logic [tkm_pkg::SRC_W-1:0]  tick_source;
  logic [tkm_pkg::TIME_W-1:0] tick_time;
  logic [tkm_pkg::PL_W-1:0]   tick_payload;

  modport source (output valid, op, tick_source, tick_time, tick_payload, input ready);
  modport sink   (input valid, op, tick_source, tick_time, tick_payload, output ready);
endinterface

interface tkm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [tkm_pkg::SRC_W-1:0]  out_source;
  logic [tkm_pkg::TIME_W-1:0] out_time;
  logic [tkm_pkg::PL_W-1:0]   out_payload;

  modport source (output valid, found, out_source, out_time, out_payload, input ready);
  modport sink   (input valid, found, out_source, out_time, out_payload, output ready);
endinterface

// ----- hdl/tkm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- hdl/tkm_ctrl.sv -----
// Controller state machine of the timestamp merge: accepts words and sequences the head scan.
module tkm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [tkm_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  tkm_pkg::tkm_stat_t       stat,
  output tkm_pkg::tkm_cmd_t        cmd
);
  import tkm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    in_ready  = (state_r == S_IDLE) && !stat.out_busy;
    accept    = in_valid && in_ready;
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LOAD: begin
              cmd.head_wr  = 1'b1;
              cmd.res_zero = 1'b1;
            end
            OP_REMOVE: begin
              cmd.head_rm  = 1'b1;
              cmd.res_zero = 1'b1;
            end
            OP_STEP: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: begin
              cmd.res_zero = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last head read is compared during this cycle.
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.res_best = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/tkm_dpath.sv -----
// Datapath of the timestamp merge: head memory, valid marks, running minimum and result register.
module tkm_dpath #(
  parameter int NUM_SOURCES   = tkm_pkg::NUM_SOURCES_DEF,
  parameter int PAYLOAD_WIDTH = tkm_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tkm_pkg::tkm_cmd_t          cmd,
  output tkm_pkg::tkm_stat_t         stat,
  input  logic [tkm_pkg::SRC_W-1:0]  in_source,
  input  logic [tkm_pkg::TIME_W-1:0] in_time,
  input  logic [tkm_pkg::PL_W-1:0]   in_payload,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [tkm_pkg::SRC_W-1:0]  out_source,
  output logic [tkm_pkg::TIME_W-1:0] out_time,
  output logic [tkm_pkg::PL_W-1:0]   out_payload
);
  import tkm_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SOURCES);
  localparam int KEEP_W = (PAYLOAD_WIDTH < PL_W) ? PAYLOAD_WIDTH : PL_W;
  localparam int ENT_W  = TIME_W + KEEP_W;

  logic [NUM_SOURCES-1:0] hv_r;
  logic                   src_ok;
  logic [IDX_W-1:0]       wr_idx;
  logic [ENT_W-1:0]       rd_ent;
  logic [TIME_W-1:0]      ent_time;
  logic [KEEP_W-1:0]      ent_pl;

  logic [IDX_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic              p1_vld_r;
  logic [IDX_W-1:0]  p1_idx_r;
  logic              any_r;
  logic              cand;
  logic [IDX_W-1:0]  best_idx_r;
  logic [TIME_W-1:0] best_time_r;
  logic [KEEP_W-1:0] best_pl_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [SRC_W-1:0]  out_source_r;
  logic [TIME_W-1:0] out_time_r;
  logic [PL_W-1:0]   out_payload_r;

  // Sources beyond the configured count are ignored.
  assign src_ok = 32'(in_source) < NUM_SOURCES;
  assign wr_idx = IDX_W'(in_source);

  tkm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_SOURCES)
  ) u_heads (
    .clk  (clk),
    .we   (cmd.head_wr && src_ok),
    .waddr(wr_idx),
    .wdata({KEEP_W'(in_payload), in_time}),
    .re   (cmd.scan_rd),
    .raddr(rd_addr_r),
    .rdata(rd_ent)
  );

  assign ent_time = rd_ent[TIME_W-1:0];
  assign ent_pl   = rd_ent[ENT_W-1:TIME_W];

  // Strict less-than keeps the lowest index among equal times.
  assign cand = p1_vld_r && hv_r[p1_idx_r] && (!any_r || (ent_time < best_time_r));

  always_comb begin
    rd_addr_nxt = rd_addr_r;
    if (cmd.scan_clr) begin
      rd_addr_nxt = '0;
    end else if (cmd.scan_rd) begin
      rd_addr_nxt = rd_addr_r + 1'b1;
    end
  end

  assign stat = '{out_busy: out_valid_r && !out_ready,
                  rd_last:  rd_addr_r == IDX_W'(NUM_SOURCES - 1)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= '0;
      rd_addr_r   <= '0;
      p1_vld_r    <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_addr_r <= rd_addr_nxt;
      p1_vld_r  <= cmd.scan_rd;
      if (cmd.head_wr && src_ok) begin
        hv_r[wr_idx] <= 1'b1;
      end
      if (cmd.head_rm && src_ok) begin
        hv_r[wr_idx] <= 1'b0;
      end
      if (cmd.res_best && any_r) begin
        hv_r[best_idx_r] <= 1'b0;
      end
      if (cmd.scan_clr) begin
        any_r <= 1'b0;
      end else if (cand) begin
        any_r <= 1'b1;
      end
      if (cmd.res_zero || cmd.res_best) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= rd_addr_r;
    if (cand) begin
      best_idx_r  <= p1_idx_r;
      best_time_r <= ent_time;
      best_pl_r   <= ent_pl;
    end
    if (cmd.res_zero) begin
      out_found_r   <= 1'b0;
      out_source_r  <= '0;
      out_time_r    <= '0;
      out_payload_r <= '0;
    end else if (cmd.res_best) begin
      out_found_r   <= any_r;
      out_source_r  <= any_r ? SRC_W'(best_idx_r) : '0;
      out_time_r    <= any_r ? best_time_r : '0;
      out_payload_r <= any_r ? PL_W'(best_pl_r) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_source  = out_source_r;
  assign out_time    = out_time_r;
  assign out_payload = out_payload_r;

endmodule

// ----- hdl/timestamp_kway_merge_core.sv -----
// Top level of the timestamp merge: channel ports, controller and datapath.
// This block merges up to NUM_SOURCES timestamped tick streams into one stream ordered
// by time. Each source owns one head entry (time, payload, valid mark); a load word writes
// the head and marks it valid, a remove word clears the mark, and a step word emits the
// valid head with the smallest time (lowest source index on a tie) and retires it so the
// source can load its next tick. Every input word yields exactly one result word; loads,
// removes, unused op codes and steps that find no valid head return found low with all
// fields zero. Loads and removes for a source at or beyond NUM_SOURCES are ignored. Only
// the low PAYLOAD_WIDTH bits of a payload are kept. Load, remove and unused op words post
// their result to the output register in the cycle after they are taken. A step scans the
// heads, which live in a memory with a single read port, so it reads one head per cycle
// and compares it against a running minimum, then finishes the last compare in a drain
// state and posts the result in a finish state. A new word is taken only when the block
// is idle and the output register is empty or being emptied in the same cycle. The valid
// marks are flip-flops cleared by reset, so no clearing pass runs and the block takes
// words right after reset.
module timestamp_kway_merge_core #(
  parameter int NUM_SOURCES   = tkm_pkg::NUM_SOURCES_DEF,
  parameter int PAYLOAD_WIDTH = tkm_pkg::PAYLOAD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tkm_in_if.sink    in_word,
  tkm_out_if.source out_word
);
  import tkm_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  tkm_cmd_t  cmd;
  tkm_stat_t stat;

  // The controller decodes the op of each accepted word and, for a step, walks the
  // scan through its read, drain and finish phases.
  tkm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_word.valid),
    .in_op   (in_word.op),
    .in_ready(in_word.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // The datapath holds the head memory, the valid marks, the running minimum of the
  // scan and the output register that decouples the result channel from the input.
  tkm_dpath #(
    .NUM_SOURCES  (NUM_SOURCES),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_source  (in_word.tick_source),
    .in_time    (in_word.tick_time),
    .in_payload (in_word.tick_payload),
    .out_valid  (out_word.valid),
    .out_ready  (out_word.ready),
    .out_found  (out_word.found),
    .out_source (out_word.out_source),
    .out_time   (out_word.out_time),
    .out_payload(out_word.out_payload)
  );

endmodule

// ----- hdl/tkm_checker.sv -----
// Port-level assertion checker for the timestamp merge and its bind to the top level.
`include "timestamp_kway_merge_core_macros.svh"

module tkm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [tkm_pkg::OP_W-1:0]   in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [tkm_pkg::SRC_W-1:0]  out_source,
  input logic [tkm_pkg::TIME_W-1:0] out_time,
  input logic [tkm_pkg::PL_W-1:0]   out_payload
);
  import tkm_pkg::*;

  // A stalled result word stays valid and holds its time and source.
  `TKM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_time) && $stable(out_source),
    "result word changed while stalled")

  // An empty result carries all-zero fields.
  `TKM_ASSERT_NOW(a_empty_zero, out_valid && !out_found,
    (out_source == '0) && (out_time == '0) && (out_payload == '0),
    "empty result with nonzero fields")

  // A step keeps the block busy while it scans the heads.
  `TKM_ASSERT_NEXT(a_step_busy, in_valid && in_ready && (in_op == OP_STEP),
    !in_ready && !out_valid, "input taken or result posted right after a step")

  // Every word that is not a step gives an empty result on the next cycle.
  `TKM_ASSERT_NEXT(a_nonstep_res, in_valid && in_ready && (in_op != OP_STEP),
    out_valid && !out_found, "missing empty result after a non-step word")

endmodule

bind timestamp_kway_merge_core tkm_checker u_tkm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .in_op      (in_word.op),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_found  (out_word.found),
  .out_source (out_word.out_source),
  .out_time   (out_word.out_time),
  .out_payload(out_word.out_payload)
);

// ----- sim/timestamp_kway_merge_core_tb.sv -----
// Self-checking testbench of the timestamp merge core: directed and random words, one checker.
`timescale 1ns / 100ps

module timestamp_kway_merge_core_tb;
  import tkm_pkg::*;

  // The block is built with its default sixteen sources and full-width payloads.
  localparam int NUM_SRC = NUM_SOURCES_DEF;

  // Op code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A step scans every head, so the settle time grows with NUM_SRC.
  localparam int SETTLE_CYCLES = 2 * NUM_SRC + 8;

  // Generous watchdog: about 530 words in all.
  localparam int CYCLE_LIMIT = 400000;

  // One result word, as the block should produce it.
  typedef struct {
    logic              found;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] stamp;
    logic [PL_W-1:0]   payload;
  } tick_res_t;

  logic clk;
  logic rst_n;

  tkm_in_if  in_ch ();
  tkm_out_if out_ch ();

  timestamp_kway_merge_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  // Shadow copy of the head table that the predictor keeps in step with the block.
  logic              head_live [NUM_SRC];
  logic [TIME_W-1:0] head_stamp [NUM_SRC];
  logic [PL_W-1:0]   head_data [NUM_SRC];

  // The most recently emitted source, used to steer reloads the way a real
  // producer would refill the head that was just drained.
  logic [SRC_W-1:0] last_winner;
  logic             last_winner_ok;

  // Expected result words, oldest first.
  tick_res_t expected_ticks[$];

  int err_cnt;
  int burst_left;
  int unsigned cyc;

  // Clock generation: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted word to the shadow table and returns the result that
  // the block owes for it. Loads, removes and the unused op return an all-zero
  // word; a step returns the oldest valid head, lowest index first on a tie.
  function automatic tick_res_t merge_predict(input logic [OP_W-1:0] op,
                                              input logic [SRC_W-1:0] src,
                                              input logic [TIME_W-1:0] stamp,
                                              input logic [PL_W-1:0] payload);
    tick_res_t res;
    logic      any;
    int        best;
    res = '{found: 1'b0, src: '0, stamp: '0, payload: '0};
    any  = 1'b0;
    best = 0;
    if (op == OP_LOAD) begin
      if (int'(src) < NUM_SRC) begin
        head_stamp[src] = stamp;
        head_data[src]  = payload;
        head_live[src]  = 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      if (int'(src) < NUM_SRC) head_live[src] = 1'b0;
    end else if (op == OP_STEP) begin
      // Strict less-than keeps the lowest index among equal times.
      for (int i = 0; i < NUM_SRC; i++) begin
        if (head_live[i] && (!any || head_stamp[i] < head_stamp[best])) begin
          best = i;
          any  = 1'b1;
        end
      end
      if (any) begin
        res.found   = 1'b1;
        res.src     = SRC_W'(best);
        res.stamp   = head_stamp[best];
        res.payload = head_data[best];
        head_live[best] = 1'b0;
        last_winner     = SRC_W'(best);
        last_winner_ok  = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // Timestamps for loads: a narrow band makes ties common, the rest covers
  // the full range and both ends of it.
  function automatic logic [TIME_W-1:0] pick_stamp();
    case ($urandom_range(0, 5))
      0, 1: return TIME_W'($urandom_range(0, 7));
      2:    return '1;
      3:    return '1 - TIME_W'($urandom_range(0, 3));
      4:    return '0;
      default: return rand_stamp();
    endcase
  endfunction

  // Offers one word and holds it until the block takes it. Valid is left high
  // when the burst goes on, so the next word follows in the cycle after; when
  // the burst ends the sender drops valid and idles for a random gap.
  task automatic put_word(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] src,
                          input logic [TIME_W-1:0] stamp, input logic [PL_W-1:0] payload);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.tick_source  <= src;
    in_ch.tick_time    <= stamp;
    in_ch.tick_payload <= payload;
    do @(posedge clk); while (!in_ch.ready);
    expected_ticks.insert(expected_ticks.size(), merge_predict(op, src, stamp, payload));
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      // Now and then a long burst gives a stretch with no sender idling.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stops sending and waits until every expected result word has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  // A step on an empty table, a remove of a head that was never loaded, and the
  // unused op code with every field bit set, then one ordinary load and step.
  task automatic test_empty_and_unused();
    put_word(OP_STEP, 4'hF, '1, '1);
    put_word(OP_REMOVE, 4'd9, '0, '0);
    put_word(OP_UNUSED, 4'hF, '1, '1);
    put_word(OP_LOAD, 4'd3, 64'd100, 32'hA5A5_5A5A);
    put_word(OP_STEP, 4'd0, '0, '0);
    drain_results();
  endtask

  // Field extremes: time zero on the highest source, all-ones time on the
  // lowest, and all-ones and all-zero payloads; the last step finds nothing.
  task automatic test_extremes();
    put_word(OP_LOAD, 4'd0, '1, '1);
    put_word(OP_LOAD, 4'hF, '0, '0);
    put_word(OP_STEP, 4'd0, '0, '0);
    put_word(OP_STEP, 4'd0, '0, '0);
    put_word(OP_STEP, 4'd0, '0, '0);
    drain_results();
  endtask

  // Equal times across several sources: they must come out in index order,
  // including a tie at the maximum time.
  task automatic test_ties();
    put_word(OP_LOAD, 4'd12, 64'd7, 32'h0000_000C);
    put_word(OP_LOAD, 4'd2,  64'd7, 32'h0000_0002);
    put_word(OP_LOAD, 4'd8,  '1,    32'h0000_0008);
    put_word(OP_LOAD, 4'd1,  '1,    32'h0000_0001);
    repeat (4) put_word(OP_STEP, 4'd0, '0, '0);
    drain_results();
  endtask

  // A load onto a live head replaces it, a remove takes a head out of the
  // race, and a second remove of the same head changes nothing.
  task automatic test_overwrite_remove();
    put_word(OP_LOAD, 4'd5, 64'd50, 32'h1111_1111);
    put_word(OP_LOAD, 4'd5, 64'd10, 32'h2222_2222);
    put_word(OP_LOAD, 4'd6, 64'd5,  32'h3333_3333);
    put_word(OP_REMOVE, 4'd6, '0, '0);
    put_word(OP_REMOVE, 4'd6, '0, '0);
    put_word(OP_STEP, 4'd0, '0, '0);
    put_word(OP_STEP, 4'd0, '0, '0);
    drain_results();
  endtask

  // Random merge traffic. Most words are loads and steps, with loads often
  // refilling the source that was just emitted, as a live merge would; removes
  // and unused op words are sprinkled in. Halfway through the sender holds off
  // until every pending result has come back.
  task automatic test_random_merge();
    int               r;
    logic [SRC_W-1:0] s;
    for (int n = 0; n < 500; n++) begin
      if (n == 250) drain_results();
      r = $urandom_range(0, 99);
      s = SRC_W'($urandom_range(0, NUM_SRC - 1));
      if (r < 45) begin
        if (last_winner_ok && $urandom_range(0, 1) == 1) s = last_winner;
        put_word(OP_LOAD, s, pick_stamp(), $urandom);
      end else if (r < 52) begin
        put_word(OP_REMOVE, s, rand_stamp(), $urandom);
      end else if (r < 92) begin
        // Step words carry random fields that the block must ignore.
        put_word(OP_STEP, s, rand_stamp(), $urandom);
      end else begin
        put_word(OP_UNUSED, s, rand_stamp(), $urandom);
      end
    end
    drain_results();
  endtask

  // Receiver back-pressure and the watchdog. The receiver cycles through four
  // moods, picked by bits 8:7 of the cycle count: always ready, mostly ready,
  // mostly stalled, and a fixed one-in-eight stall.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (cyc[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cyc[2:0] != 3'd0);
      endcase
    end
    if (cyc == CYCLE_LIMIT) begin
      $display("FAIL timestamp_kway_merge_core");
      $finish;
    end
  end

  // Result checker: each word taken from the block is matched against the
  // oldest expectation, field by field.
  always @(posedge clk) begin
    tick_res_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        $error("unexpected result word: found %0b source %0d time %h payload %h",
               out_ch.found, out_ch.out_source, out_ch.out_time, out_ch.out_payload);
        err_cnt++;
      end else begin
        exp_res = expected_ticks.pop_front();
        if (out_ch.found !== exp_res.found) begin
          $error("found: expected %0b, got %0b", exp_res.found, out_ch.found);
          err_cnt++;
        end
        if (out_ch.out_source !== exp_res.src) begin
          $error("out_source: expected %0d, got %0d", exp_res.src, out_ch.out_source);
          err_cnt++;
        end
        if (out_ch.out_time !== exp_res.stamp) begin
          $error("out_time: expected %h, got %h", exp_res.stamp, out_ch.out_time);
          err_cnt++;
        end
        if (out_ch.out_payload !== exp_res.payload) begin
          $error("out_payload: expected %h, got %h", exp_res.payload, out_ch.out_payload);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence: reset once, then each test in turn, then the final verdict.
  initial begin
    err_cnt        = 0;
    burst_left     = 0;
    last_winner    = '0;
    last_winner_ok = 1'b0;
    for (int i = 0; i < NUM_SRC; i++) begin
      head_live[i]  = 1'b0;
      head_stamp[i] = '0;
      head_data[i]  = '0;
    end
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_LOAD;
    in_ch.tick_source  <= '0;
    in_ch.tick_time    <= '0;
    in_ch.tick_payload <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_unused();
    test_extremes();
    test_ties();
    test_overwrite_remove();
    test_random_merge();

    // Give the block time to show any stray result word after the last one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      $error("%0d expected result words never arrived", expected_ticks.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS timestamp_kway_merge_core");
    end else begin
      $display("FAIL timestamp_kway_merge_core");
    end
    $finish;
  end

endmodule
